// File: hw/rtl/vsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel stair line package
// Types and constants shared by the voxel stair line generator modules.
// ----------------------------------------------------------------------------
package vsl_pkg;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned CELL_W    = 6;
  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned NUM_QUANT = 6;
  localparam int unsigned QSEL_W    = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [QSEL_W-1:0]    qsel_t;
  typedef logic [CELL_W-1:0]    cell_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t REG_ORIGIN_X = 3'd0;
  localparam cfg_idx_t REG_ORIGIN_Y = 3'd1;
  localparam cfg_idx_t REG_ORIGIN_Z = 3'd2;
  localparam cfg_idx_t REG_TOP_X    = 3'd3;
  localparam cfg_idx_t REG_TOP_Y    = 3'd4;
  localparam cfg_idx_t REG_TOP_Z    = 3'd5;
  localparam cfg_idx_t REG_CPM      = 3'd6;

  // Reset values: a 63 m cube at the origin, one cell per metre.
  localparam logic [CFG_W-1:0] RST_ORIGIN = 32'd0;
  localparam logic [CFG_W-1:0] RST_TOP    = 32'd4128768;
  localparam logic [CFG_W-1:0] RST_CPM    = 32'd65536;

  // Quantizer slots: the three start coordinates, then the three end ones.
  localparam qsel_t Q_SX = 3'd0;
  localparam qsel_t Q_SY = 3'd1;
  localparam qsel_t Q_SZ = 3'd2;
  localparam qsel_t Q_EX = 3'd3;
  localparam qsel_t Q_EY = 3'd4;
  localparam qsel_t Q_EZ = 3'd5;

  typedef struct packed {
    logic signed [CFG_W-1:0] origin_x;
    logic signed [CFG_W-1:0] origin_y;
    logic signed [CFG_W-1:0] origin_z;
    logic signed [CFG_W-1:0] top_x;
    logic signed [CFG_W-1:0] top_y;
    logic signed [CFG_W-1:0] top_z;
    logic        [CFG_W-1:0] cpm;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  mul_en;
    qsel_t mul_sel;
    logic  store_en;
    qsel_t store_sel;
    logic  setup;
    logic  step;
    logic  emit_err;
  } dp_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic n_zero;
    logic step_last;
  } dp_sts_t;

endpackage

// File: hw/rtl/vsl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel stair line configuration registers
// Holds the grid box corners and the cell density, written by index.
// ----------------------------------------------------------------------------
module vsl_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  vsl_pkg::cfg_idx_t             cfg_addr,
  input  logic [vsl_pkg::CFG_W-1:0]     cfg_wdata,
  output vsl_pkg::cfg_t                 cfg
);

  vsl_pkg::cfg_t cfg_r;
  vsl_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        vsl_pkg::REG_ORIGIN_X: cfg_nxt.origin_x = cfg_wdata;
        vsl_pkg::REG_ORIGIN_Y: cfg_nxt.origin_y = cfg_wdata;
        vsl_pkg::REG_ORIGIN_Z: cfg_nxt.origin_z = cfg_wdata;
        vsl_pkg::REG_TOP_X:    cfg_nxt.top_x    = cfg_wdata;
        vsl_pkg::REG_TOP_Y:    cfg_nxt.top_y    = cfg_wdata;
        vsl_pkg::REG_TOP_Z:    cfg_nxt.top_z    = cfg_wdata;
        vsl_pkg::REG_CPM:      cfg_nxt.cpm      = cfg_wdata;
        default:               cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= vsl_pkg::RST_ORIGIN;
      cfg_r.origin_y <= vsl_pkg::RST_ORIGIN;
      cfg_r.origin_z <= vsl_pkg::RST_ORIGIN;
      cfg_r.top_x    <= vsl_pkg::RST_TOP;
      cfg_r.top_y    <= vsl_pkg::RST_TOP;
      cfg_r.top_z    <= vsl_pkg::RST_TOP;
      cfg_r.cpm      <= vsl_pkg::RST_CPM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/vsl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel stair line controller
// Sequences quantization, line setup and cell emission for one request.
// ----------------------------------------------------------------------------
module vsl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  vsl_pkg::dp_sts_t  sts,
  output vsl_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUANT,
    ST_SETUP,
    ST_EMIT,
    ST_ERR
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  vsl_pkg::qsel_t     cnt_r;
  vsl_pkg::qsel_t     cnt_nxt;
  logic               busy_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = ST_QUANT;
        end
      end
      ST_QUANT: begin
        if (cnt_r == vsl_pkg::QSEL_W'(vsl_pkg::NUM_QUANT)) begin
          state_nxt = ST_SETUP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SETUP: begin
        state_nxt = sts.range_ok ? ST_EMIT : ST_ERR;
      end
      ST_EMIT: begin
        if (sts.n_zero || sts.step_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == ST_IDLE) && start;
    cmd.mul_en    = (state_r == ST_QUANT) &&
                    (cnt_r != vsl_pkg::QSEL_W'(vsl_pkg::NUM_QUANT));
    cmd.mul_sel   = cnt_r;
    cmd.store_en  = (state_r == ST_QUANT) && (cnt_r != '0);
    cmd.store_sel = cnt_r - 1'b1;
    cmd.setup     = (state_r == ST_SETUP);
    cmd.step      = (state_r == ST_EMIT) && !sts.n_zero;
    cmd.emit_err  = (state_r == ST_ERR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// File: hw/rtl/vsl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel stair line datapath
// Range check, shared quantizing multiplier, and incremental line stepping.
// ----------------------------------------------------------------------------
module vsl_dp #(
  parameter int unsigned GRID_MAX  = 63,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vsl_pkg::cfg_t                       cfg,
  input  vsl_pkg::dp_cmd_t                    cmd,
  output vsl_pkg::dp_sts_t                    sts,
  input  logic signed [vsl_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [vsl_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [vsl_pkg::COORD_W-1:0]  in_start_z,
  input  logic signed [vsl_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [vsl_pkg::COORD_W-1:0]  in_end_y,
  input  logic signed [vsl_pkg::COORD_W-1:0]  in_end_z,
  output logic                                out_valid,
  output vsl_pkg::cell_t                      out_cell_u,
  output vsl_pkg::cell_t                      out_cell_v,
  output vsl_pkg::cell_t                      out_cell_t,
  output logic                                out_last,
  output logic                                out_out_of_range
);

  localparam int unsigned PROD_W = 2 * vsl_pkg::COORD_W;
  localparam int unsigned SHIFT  = 2 * FRAC_BITS;
  localparam int unsigned RND_W  = PROD_W - SHIFT + 1;
  localparam int unsigned CW     = vsl_pkg::CELL_W;

  // Captured request.
  logic signed [vsl_pkg::COORD_W-1:0] pt_r [vsl_pkg::NUM_QUANT];
  logic                               ok_r;

  // Quantizer.
  logic signed [vsl_pkg::COORD_W-1:0] p_sel;
  logic signed [vsl_pkg::COORD_W-1:0] lo_sel;
  logic signed [vsl_pkg::COORD_W-1:0] hi_sel;
  logic [vsl_pkg::COORD_W-1:0]        diff;
  logic                               in_range;
  logic [PROD_W-1:0]                  prod_r;
  logic [RND_W-1:0]                   rnd;
  vsl_pkg::cell_t                     qcell;
  vsl_pkg::cell_t                     cell_r [vsl_pkg::NUM_QUANT];

  // Line set-up and stepping.
  vsl_pkg::cell_t   s_r   [vsl_pkg::NUM_AXES];
  vsl_pkg::cell_t   mag_r [vsl_pkg::NUM_AXES];
  logic             neg_r [vsl_pkg::NUM_AXES];
  vsl_pkg::cell_t   q_r   [vsl_pkg::NUM_AXES];
  vsl_pkg::cell_t   rem_r [vsl_pkg::NUM_AXES];
  vsl_pkg::cell_t   n_r;
  vsl_pkg::cell_t   i_r;
  logic signed [CW:0] dsig  [vsl_pkg::NUM_AXES];
  vsl_pkg::cell_t     mag_c [vsl_pkg::NUM_AXES];
  vsl_pkg::cell_t     n_c;
  logic [CW:0]        acc   [vsl_pkg::NUM_AXES];
  vsl_pkg::cell_t     coord [vsl_pkg::NUM_AXES];
  vsl_pkg::cell_t     q_nxt [vsl_pkg::NUM_AXES];
  vsl_pkg::cell_t     rem_nxt [vsl_pkg::NUM_AXES];

  // Output register.
  logic           out_valid_r;
  vsl_pkg::cell_t out_cell_r [vsl_pkg::NUM_AXES];
  logic           out_last_r;
  logic           out_oor_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    p_sel  = pt_r[cmd.mul_sel];
    lo_sel = '0;
    hi_sel = '0;
    case (cmd.mul_sel)
      vsl_pkg::Q_SX, vsl_pkg::Q_EX: begin
        lo_sel = cfg.origin_x;
        hi_sel = cfg.top_x;
      end
      vsl_pkg::Q_SY, vsl_pkg::Q_EY: begin
        lo_sel = cfg.origin_y;
        hi_sel = cfg.top_y;
      end
      vsl_pkg::Q_SZ, vsl_pkg::Q_EZ: begin
        lo_sel = cfg.origin_z;
        hi_sel = cfg.top_z;
      end
      default: begin
        lo_sel = '0;
        hi_sel = '0;
      end
    endcase
  end

  assign in_range = (p_sel >= lo_sel) && (p_sel <= hi_sel);
  assign diff     = p_sel - lo_sel;

  // Round half up on the first dropped bit, then saturate.
  assign rnd   = RND_W'(prod_r[PROD_W-1:SHIFT]) + RND_W'(prod_r[SHIFT-1]);
  assign qcell = (rnd > RND_W'(GRID_MAX)) ? CW'(GRID_MAX) : rnd[CW-1:0];

  // Per-axis difference and the longest axis.
  always_comb begin
    n_c = '0;
    for (int k = 0; k < vsl_pkg::NUM_AXES; k++) begin
      dsig[k]  = $signed({1'b0, cell_r[k + vsl_pkg::NUM_AXES]}) -
                 $signed({1'b0, cell_r[k]});
      mag_c[k] = dsig[k][CW] ? CW'(-dsig[k]) : dsig[k][CW-1:0];
      if (mag_c[k] > n_c) begin
        n_c = mag_c[k];
      end
    end
  end

  // Quotient and remainder of i*|d|/n advance by at most one per step.
  always_comb begin
    for (int k = 0; k < vsl_pkg::NUM_AXES; k++) begin
      coord[k] = neg_r[k] ? (s_r[k] - q_r[k]) : (s_r[k] + q_r[k]);
      acc[k]   = {1'b0, rem_r[k]} + {1'b0, mag_r[k]};
      if (acc[k] >= {1'b0, n_r}) begin
        rem_nxt[k] = CW'(acc[k] - {1'b0, n_r});
        q_nxt[k]   = q_r[k] + 1'b1;
      end else begin
        rem_nxt[k] = acc[k][CW-1:0];
        q_nxt[k]   = q_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt_r[vsl_pkg::Q_SX] <= in_start_x;
      pt_r[vsl_pkg::Q_SY] <= in_start_y;
      pt_r[vsl_pkg::Q_SZ] <= in_start_z;
      pt_r[vsl_pkg::Q_EX] <= in_end_x;
      pt_r[vsl_pkg::Q_EY] <= in_end_y;
      pt_r[vsl_pkg::Q_EZ] <= in_end_z;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(diff) * PROD_W'(cfg.cpm);
    end
    if (cmd.store_en) begin
      cell_r[cmd.store_sel] <= qcell;
    end
    if (cmd.setup) begin
      n_r <= n_c;
      i_r <= '0;
      for (int k = 0; k < vsl_pkg::NUM_AXES; k++) begin
        s_r[k]   <= cell_r[k];
        mag_r[k] <= mag_c[k];
        neg_r[k] <= dsig[k][CW];
        q_r[k]   <= '0;
        rem_r[k] <= '0;
      end
    end
    if (cmd.step) begin
      i_r <= i_r + 1'b1;
      for (int k = 0; k < vsl_pkg::NUM_AXES; k++) begin
        q_r[k]   <= q_nxt[k];
        rem_r[k] <= rem_nxt[k];
      end
    end
    if (cmd.step) begin
      for (int k = 0; k < vsl_pkg::NUM_AXES; k++) begin
        out_cell_r[k] <= coord[k];
      end
      out_last_r <= (i_r == n_r);
      out_oor_r  <= 1'b0;
    end else if (cmd.emit_err) begin
      for (int k = 0; k < vsl_pkg::NUM_AXES; k++) begin
        out_cell_r[k] <= '0;
      end
      out_last_r <= 1'b1;
      out_oor_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        ok_r <= 1'b1;
      end else if (cmd.mul_en) begin
        ok_r <= ok_r & in_range;
      end
      out_valid_r <= cmd.step | cmd.emit_err;
    end
  end

  assign sts.range_ok  = ok_r;
  assign sts.n_zero    = (n_r == '0);
  assign sts.step_last = (i_r == n_r);

  assign out_valid        = out_valid_r;
  assign out_cell_u       = out_cell_r[0];
  assign out_cell_v       = out_cell_r[1];
  assign out_cell_t       = out_cell_r[2];
  assign out_last         = out_last_r;
  assign out_out_of_range = out_oor_r;

endmodule

// File: hw/rtl/voxel_stair_line_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel stair line generator
// Quantizes two 3-D points onto a voxel grid and walks the stair line
// between the two cells, one cell per clock.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its two endpoints are
// checked against the configured grid box and quantized, one coordinate a
// cycle through a single 32 x 32 multiplier, then the cells of the line are
// produced one per clock on out_valid. The results cannot be held off: each
// cell is present for exactly one cycle and the receiver must take it then.
// The block stays busy for the whole request and takes no new one until it
// is done: six multiplier passes, a drain step and a set-up step, then the
// cell walk. A request with an endpoint outside the box yields one result
// flagged out_out_of_range with last set and zero cells; a request whose
// endpoints fall in the same cell yields no result at all. The configuration
// registers should only be written while busy is low and no cell is still to
// come.
module voxel_stair_line_generator #(
  parameter int unsigned GRID_MAX  = 63,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [vsl_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [vsl_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [vsl_pkg::COORD_W-1:0]  in_start_z,
  input  logic signed [vsl_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [vsl_pkg::COORD_W-1:0]  in_end_y,
  input  logic signed [vsl_pkg::COORD_W-1:0]  in_end_z,
  input  logic                                cfg_we,
  input  vsl_pkg::cfg_idx_t                   cfg_addr,
  input  logic [vsl_pkg::CFG_W-1:0]           cfg_wdata,
  output logic                                out_valid,
  output vsl_pkg::cell_t                      out_cell_u,
  output vsl_pkg::cell_t                      out_cell_v,
  output vsl_pkg::cell_t                      out_cell_t,
  output logic                                out_last,
  output logic                                out_out_of_range
);

  vsl_pkg::cfg_t    cfg;
  vsl_pkg::dp_cmd_t cmd;
  vsl_pkg::dp_sts_t sts;

  // Box corners and cell density.
  vsl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sequencer: accepts the request and steps the datapath through its phases.
  vsl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Range check, quantizer, line walker and the output register.
  vsl_dp #(
    .GRID_MAX  (GRID_MAX),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_start_z       (in_start_z),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_end_z         (in_end_z),
    .out_valid        (out_valid),
    .out_cell_u       (out_cell_u),
    .out_cell_v       (out_cell_v),
    .out_cell_t       (out_cell_t),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

  // An accepted request always makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // Cells of one line come out on consecutive cycles up to the last one.
  a_line_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a line");

  // An error result closes its request and carries zero cells.
  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      out_last && (out_cell_u == '0) && (out_cell_v == '0) && (out_cell_t == '0))
    else $error("malformed out-of-range result");

  // A new line cannot start while cells of the previous one are still due.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("request accepted in the middle of a line");

endmodule

// File: dv/voxel_stair_line_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel stair line generator testbench
// Drives line requests through the command port, rewrites the grid box
// between phases and checks every cell, in order, against a local
// prediction of the quantizer and the stair walk.
// ----------------------------------------------------------------------------
module voxel_stair_line_generator_tb;

  localparam int GRID_MAX     = 63;
  localparam int FRAC_BITS    = 16;
  // A register write waits for this many quiet cycles first, with no request,
  // busy flag or predicted cell outstanding.
  localparam int QUIET_CYCLES = 12;
  // Longest line: 64 cells plus the fixed quantizer set-up.
  localparam int TAIL_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 600000;

  // The pending stimulus holds line requests, register writes and pauses in
  // the order in which they are to be issued.
  typedef enum logic [1:0] {
    OP_LINE,
    OP_CFG,
    OP_DRAIN
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    vsl_pkg::cfg_idx_t idx;
    logic [31:0]       wdata;
    logic [2:0][31:0]  p0;  // start point, index 0 is x
    logic [2:0][31:0]  p1;  // end point
  } stim_op_t;

  typedef struct packed {
    vsl_pkg::cell_t u;
    vsl_pkg::cell_t v;
    vsl_pkg::cell_t t;
    logic           last;
    logic           oor;
  } cell_result_t;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              start            = 1'b0;
  logic              busy;
  logic [31:0]       in_start_x       = '0;
  logic [31:0]       in_start_y       = '0;
  logic [31:0]       in_start_z       = '0;
  logic [31:0]       in_end_x         = '0;
  logic [31:0]       in_end_y         = '0;
  logic [31:0]       in_end_z         = '0;
  logic              cfg_we           = 1'b0;
  vsl_pkg::cfg_idx_t cfg_addr         = vsl_pkg::REG_ORIGIN_X;
  logic [31:0]       cfg_wdata        = '0;
  logic              out_valid;
  vsl_pkg::cell_t    out_cell_u;
  vsl_pkg::cell_t    out_cell_v;
  vsl_pkg::cell_t    out_cell_t;
  logic              out_last;
  logic              out_out_of_range;

  stim_op_t     pending[$];
  cell_result_t cells_due[$];
  stim_op_t     cur_req = '0;

  // Grid box as the block holds it, updated when a write is issued.
  logic signed [31:0] grid_lo[3];
  logic signed [31:0] grid_hi[3];
  logic        [31:0] grid_cpm;

  // Grid box that the stimulus being planned will meet.
  logic signed [31:0] plan_lo[3];
  logic signed [31:0] plan_hi[3];

  int gap_left     = 0;
  int burst_left   = 1;
  int idle_run     = 0;
  int cycle_count  = 0;
  int mismatches   = 0;
  int lines_taken  = 0;
  int lines_oor    = 0;
  int lines_silent = 0;
  int cells_seen   = 0;
  int reg_writes   = 0;
  int grid_phases  = 1;

  voxel_stair_line_generator #(
    .GRID_MAX (GRID_MAX),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_start_z      (in_start_z),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_end_z        (in_end_z),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_cell_u      (out_cell_u),
    .out_cell_v      (out_cell_v),
    .out_cell_t      (out_cell_t),
    .out_last        (out_last),
    .out_out_of_range(out_out_of_range)
  );

  always #5 clk = ~clk;

  // Cell index of one coordinate: the offset from the lower corner times the
  // cell density, rounded half up from the first dropped bit, saturated.
  function automatic int cell_of(logic signed [31:0] p, logic signed [31:0] lo);
    logic [31:0] offset;
    logic [63:0] prod;
    logic [63:0] whole;
    offset = p - lo;
    prod   = {32'd0, offset} * {32'd0, grid_cpm};
    whole  = (prod >> (2 * FRAC_BITS)) + prod[2 * FRAC_BITS - 1];
    if (whole > GRID_MAX) begin
      whole = 64'(GRID_MAX);
    end
    return int'(whole);
  endfunction

  // Works out every cell that an accepted request must produce and queues it.
  function automatic void walk_stair_line(stim_op_t r);
    logic signed [31:0] a;
    logic signed [31:0] b;
    int                 from_c[3];
    int                 step_d[3];
    int                 span;
    int                 k;
    int                 i;
    bit                 fits;
    cell_result_t       c;
    fits = 1'b1;
    span = 0;
    for (k = 0; k < 3; k++) begin
      a = r.p0[k];
      b = r.p1[k];
      if (a < grid_lo[k] || a > grid_hi[k] || b < grid_lo[k] || b > grid_hi[k]) begin
        fits = 1'b0;
      end
    end
    if (!fits) begin
      c      = '0;
      c.last = 1'b1;
      c.oor  = 1'b1;
      cells_due = {cells_due, c};
      lines_oor++;
      return;
    end
    for (k = 0; k < 3; k++) begin
      from_c[k] = cell_of(r.p0[k], grid_lo[k]);
      step_d[k] = cell_of(r.p1[k], grid_lo[k]) - from_c[k];
      if (step_d[k] > span) span = step_d[k];
      if (-step_d[k] > span) span = -step_d[k];
    end
    if (span == 0) begin
      lines_silent++;
      return;
    end
    // Integer division here truncates toward zero, as the walk requires.
    for (i = 0; i <= span; i++) begin
      c.u    = vsl_pkg::cell_t'(from_c[0] + (i * step_d[0]) / span);
      c.v    = vsl_pkg::cell_t'(from_c[1] + (i * step_d[1]) / span);
      c.t    = vsl_pkg::cell_t'(from_c[2] + (i * step_d[2]) / span);
      c.last = (i == span);
      c.oor  = 1'b0;
      cells_due = {cells_due, c};
    end
  endfunction

  // Reports one field that differs from its prediction; returns 1 on a miss.
  function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic logic [31:0] q16(int metres);
    return metres <<< FRAC_BITS;
  endfunction

  // A random coordinate on one axis inside the box being planned.
  function automatic logic [31:0] in_box(int k);
    longint w;
    w = longint'(plan_hi[k]) - longint'(plan_lo[k]) + 1;
    return 32'(plan_lo[k] + ({$urandom, $urandom} % w));
  endfunction

  task automatic queue_line(input logic [31:0] sx, sy, sz, ex, ey, ez);
    stim_op_t op;
    op      = '0;
    op.kind = OP_LINE;
    op.p0   = {sz, sy, sx};
    op.p1   = {ez, ey, ex};
    pending = {pending, op};
  endtask

  task automatic queue_cfg(input vsl_pkg::cfg_idx_t idx, input logic [31:0] value);
    stim_op_t op;
    op       = '0;
    op.kind  = OP_CFG;
    op.idx   = idx;
    op.wdata = value;
    pending  = {pending, op};
  endtask

  // Rewrites the whole grid box and records it for the planning of requests.
  task automatic queue_box(input logic [31:0] ox, oy, oz, tx, ty, tz, cpm);
    queue_cfg(vsl_pkg::REG_ORIGIN_X, ox);
    queue_cfg(vsl_pkg::REG_ORIGIN_Y, oy);
    queue_cfg(vsl_pkg::REG_ORIGIN_Z, oz);
    queue_cfg(vsl_pkg::REG_TOP_X, tx);
    queue_cfg(vsl_pkg::REG_TOP_Y, ty);
    queue_cfg(vsl_pkg::REG_TOP_Z, tz);
    queue_cfg(vsl_pkg::REG_CPM, cpm);
    plan_lo = '{ox, oy, oz};
    plan_hi = '{tx, ty, tz};
  endtask

  // Request driver. A request that is taken at this edge is predicted before
  // the next one is loaded, so start is only ever assigned once per edge and
  // stays high across back-to-back requests within a burst. Register writes
  // and pauses wait until the block has been idle with nothing outstanding.
  always @(posedge clk) begin : drive_requests
    logic     go_nx;
    logic     we_nx;
    stim_op_t op;
    go_nx = start;
    we_nx = 1'b0;
    if (!rst_n) begin
      go_nx = 1'b0;
    end else begin
      if (start && !busy) begin
        walk_stair_line(cur_req);
        lines_taken++;
        go_nx = 1'b0;
      end
      if (start || busy || cells_due.size() != 0) begin
        idle_run = 0;
      end else if (idle_run < QUIET_CYCLES) begin
        idle_run++;
      end
      if (!go_nx && pending.size() != 0) begin
        op = pending[0];
        case (op.kind)
          OP_LINE: begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              cur_req = pending.pop_front();
              in_start_x <= op.p0[0];
              in_start_y <= op.p0[1];
              in_start_z <= op.p0[2];
              in_end_x   <= op.p1[0];
              in_end_y   <= op.p1[1];
              in_end_z   <= op.p1[2];
              go_nx = 1'b1;
              if (burst_left > 1) begin
                burst_left--;
              end else if ($urandom_range(0, 9) == 0) begin
                // An occasional long stretch with no idling at all.
                burst_left = 40;
                gap_left   = 0;
              end else begin
                burst_left = $urandom_range(1, 12);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
              end
            end
          end
          OP_CFG: begin
            if (idle_run == QUIET_CYCLES) begin
              void'(pending.pop_front());
              cfg_addr  <= op.idx;
              cfg_wdata <= op.wdata;
              we_nx = 1'b1;
              reg_writes++;
              case (op.idx)
                vsl_pkg::REG_ORIGIN_X: grid_lo[0] = op.wdata;
                vsl_pkg::REG_ORIGIN_Y: grid_lo[1] = op.wdata;
                vsl_pkg::REG_ORIGIN_Z: grid_lo[2] = op.wdata;
                vsl_pkg::REG_TOP_X:    grid_hi[0] = op.wdata;
                vsl_pkg::REG_TOP_Y:    grid_hi[1] = op.wdata;
                vsl_pkg::REG_TOP_Z:    grid_hi[2] = op.wdata;
                vsl_pkg::REG_CPM: begin
                  grid_cpm = op.wdata;
                  grid_phases++;
                end
                default: ;
              endcase
            end
          end
          default: begin
            // A plain pause: the sender holds off until every cell is home.
            if (idle_run == QUIET_CYCLES) begin
              void'(pending.pop_front());
            end
          end
        endcase
      end
    end
    start  <= go_nx;
    cfg_we <= we_nx;
  end

  // Cell monitor. Results cannot be held off, so every strobed cell is taken
  // at the edge that ends its cycle and matched against the oldest prediction.
  always @(posedge clk) begin : check_cells
    cell_result_t want;
    if (rst_n && out_valid) begin
      cells_seen++;
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected cell, expected none, got u=%0d v=%0d t=%0d last=%0b oor=%0b",
                 $time, out_cell_u, out_cell_v, out_cell_t, out_last, out_out_of_range);
        mismatches++;
      end else begin
        want = cells_due.pop_front();
        mismatches += field_bad("cell_u", want.u, out_cell_u);
        mismatches += field_bad("cell_v", want.v, out_cell_v);
        mismatches += field_bad("cell_t", want.t, out_cell_t);
        mismatches += field_bad("last", want.last, out_last);
        mismatches += field_bad("out_of_range", want.oor, out_out_of_range);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not complete within %0d cycles, %0d cells outstanding",
               $time, CYCLE_LIMIT, cells_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : run
    logic [31:0] a[3];
    logic [31:0] b[3];
    logic [31:0] cpm;
    logic [31:0] lo_edge;
    logic [31:0] hi_edge;
    longint      span;
    longint      room;
    longint      lo64;
    int          ph;
    int          n;
    int          k;
    int          sel;

    // Reset values of the block: a 63 m cube at the origin, one cell a metre.
    grid_lo  = '{vsl_pkg::RST_ORIGIN, vsl_pkg::RST_ORIGIN, vsl_pkg::RST_ORIGIN};
    grid_hi  = '{vsl_pkg::RST_TOP, vsl_pkg::RST_TOP, vsl_pkg::RST_TOP};
    grid_cpm = vsl_pkg::RST_CPM;
    plan_lo  = grid_lo;
    plan_hi  = grid_hi;

    // Directed requests on the reset grid. The full diagonal is the longest
    // line; then falling axes, uneven steps where truncation toward zero
    // matters, coincident cells, rounding exactly at half a cell, both field
    // extremes and points one step either side of the box faces.
    queue_line(q16(0), q16(0), q16(0), q16(63), q16(63), q16(63));
    queue_line(q16(63), q16(0), q16(10), q16(0), q16(63), q16(10));
    queue_line(q16(0), q16(0), q16(0), q16(63), q16(1), q16(2));
    queue_line(q16(10), q16(10), q16(10), q16(3), q16(20), q16(7));
    queue_line(q16(5), q16(5), q16(5), 32'h0005_4CCC, 32'h0005_3333, 32'h0004_B333);
    queue_line(32'h0000_8000, q16(0), q16(0), 32'h0000_7FFF, q16(0), q16(2));
    queue_line(32'h8000_0000, q16(1), q16(1), q16(2), q16(2), q16(2));
    queue_line(q16(1), q16(1), q16(1), q16(2), q16(2), 32'h7FFF_FFFF);
    queue_line(q16(4), 32'hFFFF_FFFF, q16(4), q16(9), q16(9), q16(9));
    queue_line(q16(4), q16(4), q16(4), q16(63) + 1, q16(9), q16(9));
    queue_line(q16(62), q16(62), q16(62), q16(63), q16(63), q16(63));

    // Densest grid: one raw step is already a cell, and short offsets
    // saturate at the top cell.
    queue_box(-100, 32'h8000_0000, 1000, 100, 32'h8000_0000 + 200, 1200, 32'hFFFF_FFFF);
    queue_line(-100, 32'h8000_0000, 1000, 100, 32'h8000_0001, 1064);
    queue_line(-98, 32'h8000_0000 + 200, 1000, -100, 32'h8000_0000, 1003);

    // Zero density: every point inside falls in cell zero.
    queue_box(0, 0, 0, q16(63), q16(63), q16(63), 32'd0);
    queue_line(q16(0), q16(0), q16(0), q16(63), q16(63), q16(63));
    queue_line(q16(-1), q16(0), q16(0), q16(0), q16(0), q16(0));

    // Empty box along x: nothing can lie inside.
    queue_box(0, 0, 0, q16(-1), q16(63), q16(63), 32'd65536);
    queue_line(q16(0), q16(0), q16(0), q16(5), q16(5), q16(5));

    // The whole coordinate range as the box, with coarse cells.
    queue_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd256);
    queue_line(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_line(q16(0), q16(0), q16(0), 32'h8000_0000, 32'h7FFF_FFFF, q16(0));

    // Random phases. Each picks a density, sizes the box to seventy cells per
    // axis, or a half or a quarter of that, and places it anywhere in the
    // coordinate range; most requests then lie inside it so that real lines get walked.
    for (ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0:       cpm = 32'd65536;
        1:       cpm = $urandom_range(32'h0004_0000, 32'h0000_4000);
        2:       cpm = $urandom | 32'd1;
        default: cpm = $urandom_range(32'h0000_2000, 32'd1);
      endcase
      for (k = 0; k < 3; k++) begin
        span = ((64'd70 << 32) / cpm) >> $urandom_range(0, 2);
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        room = 64'h1_0000_0000 - span;
        lo64 = -64'sd2147483648 + longint'({$urandom, $urandom} % room);
        a[k] = lo64[31:0];
        b[k] = 32'(lo64 + span);
      end
      queue_box(a[0], a[1], a[2], b[0], b[1], b[2], cpm);
      for (n = 0; n < 70; n++) begin
        if (ph == 2 && n == 35) begin
          // Hold the sender off once until every cell has arrived.
          cur_req      = '0;
          cur_req.kind = OP_DRAIN;
          pending      = {pending, cur_req};
        end
        for (k = 0; k < 3; k++) begin
          a[k] = in_box(k);
          b[k] = in_box(k);
        end
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
          b = a;
        end else if (sel < 14) begin
          // One coordinate on a face of the box or one step beyond it.
          k       = $urandom_range(0, 2);
          lo_edge = plan_lo[k];
          hi_edge = plan_hi[k];
          case ($urandom_range(0, 3))
            0:       a[k] = lo_edge;
            1:       b[k] = hi_edge;
            2:       a[k] = lo_edge - 1;
            default: b[k] = hi_edge + 1;
          endcase
        end else if (sel < 20) begin
          for (k = 0; k < 3; k++) begin
            a[k] = $urandom;
            b[k] = $urandom;
          end
        end
        queue_line(a[0], a[1], a[2], b[0], b[1], b[2]);
      end
    end
    cur_req = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled away from the rising edge so that the driver's updates are seen.
    while (pending.size() != 0 || start || busy || cells_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d line requests over %0d grid settings and %0d register writes:",
             lines_taken, grid_phases, reg_writes);
    $display("  %0d outside the box, %0d within one cell, %0d cells compared",
             lines_oor, lines_silent, cells_seen);
    if (mismatches == 0 && cells_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
